// File: sv/lpmt_pkg.sv
// lpmt_pkg: shared types, status codes and prefix helpers for the
// ipv4 longest prefix match table; used by the cell, top level and checker
`default_nettype none

package lpmt_pkg;

    // result status codes
    localparam logic [2:0] ST_FORWARD   = 3'd0;
    localparam logic [2:0] ST_NO_ROUTE  = 3'd1;
    localparam logic [2:0] ST_DROP_SAME = 3'd2;
    localparam logic [2:0] ST_ADDED     = 3'd3;
    localparam logic [2:0] ST_PORT_OFF  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [0:0] FUNC_ADD    = 1'b0;
    localparam logic [0:0] FUNC_LOOKUP = 1'b1;

    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

    // item record that walks down the chain of cells
    typedef struct packed {
        logic        wr;         // accepted add, store at cell given by count
        logic        lookup;     // lookup item
        logic [31:0] addr;       // add: network, lookup: destination
        logic [5:0]  len;        // saturated prefix length (add)
        logic [2:0]  port;       // add: output port, lookup: arrival port
        logic        found;      // lookup: some entry matched so far
        logic [5:0]  best_len;   // lookup: length of best match so far
        logic [2:0]  best_port;  // lookup: port of best match so far
        logic [2:0]  status;     // add: final status
    } tok_t;

    // leading-ones mask for a prefix length of 0..32
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hffff_ffff >> len);
    endfunction

endpackage

`default_nettype wire

// File: sv/lpmt_cell.sv
// lpmt_cell: one table entry plus one stage of the item chain
// depends on lpmt_pkg (tok_t, prefix_mask)
`default_nettype none

module lpmt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            vld_in,
    input  wire lpmt_pkg::tok_t  tok_in,
    input  wire logic [CW-1:0]   cnt_in,
    output logic                 vld_out,
    output lpmt_pkg::tok_t       tok_out,
    output logic [CW-1:0]        cnt_out
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [31:0]    ent_network_reg;
    logic [5:0]     ent_length_reg;
    logic [2:0]     ent_port_reg;
    logic           vld_reg;
    lpmt_pkg::tok_t tok_reg;
    lpmt_pkg::tok_t tok_next;
    logic [CW-1:0]  cnt_reg;
    logic [31:0]    mask;
    logic           hit;
    logic           write_me;

    // entry match against the passing lookup
    always_comb
    begin
        mask     = lpmt_pkg::prefix_mask(ent_length_reg);
        hit      = tok_in.lookup && (cnt_in > MY_IDX)
                   && (!tok_in.found || (ent_length_reg > tok_in.best_len))
                   && ((ent_network_reg & mask) == (tok_in.addr & mask));
        write_me = vld_in && tok_in.wr && (cnt_in == MY_IDX);
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found     = 1'b1;
            tok_next.best_len  = ent_length_reg;
            tok_next.best_port = ent_port_reg;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (en && write_me)
        begin
            ent_network_reg <= tok_in.addr;
            ent_length_reg  <= tok_in.len;
            ent_port_reg    <= tok_in.port;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
            cnt_reg <= cnt_in;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    assign vld_out = vld_reg;
    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

// File: sv/ipv4_longest_prefix_match_table.sv
// ipv4_longest_prefix_match_table: top level, admission logic, chain of
// entry cells and output register; depends on lpmt_pkg and lpmt_cell
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------
//  input    | in_valid / in_stall            | func, prefix_network,
//           |                                | prefix_length, dest_address,
//           |                                | port_number
//  output   | out_valid / out_stall          | status, out_port
//  config   | active_port_mask_we            | active_port_mask_wdata
//
// one item per cycle is taken while in_stall is low; each item walks
// through the TABLE_DEPTH cell registers and then the output register,
// advancing one cell per cycle unless the chain is frozen
// an out_stall with a result waiting freezes the whole chain and raises in_stall
// reset clears the entry count, stage valids and sets the port mask to 1;
// entry contents are not cleared, entries at or above the count are ignored
`default_nettype none

module ipv4_longest_prefix_match_table #(
    parameter int TABLE_DEPTH = 128,
    parameter int NUM_PORTS   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [31:0] prefix_network,
    input  wire logic [5:0]  prefix_length,
    input  wire logic [31:0] dest_address,
    input  wire logic [2:0]  port_number,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [2:0]       out_port,
    input  wire logic        active_port_mask_we,
    input  wire logic [7:0]  active_port_mask_wdata
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);
    localparam logic [3:0]    PORT_LIMIT = 4'(NUM_PORTS);

    logic [7:0]     active_port_mask_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           advance;
    logic           accept;
    lpmt_pkg::tok_t head_tok;
    logic           port_off;
    logic           table_full;

    logic           vld     [0:TABLE_DEPTH];
    lpmt_pkg::tok_t tok     [0:TABLE_DEPTH];
    logic [CW-1:0]  cnt     [0:TABLE_DEPTH];

    logic           out_valid_reg;
    logic [2:0]     status_reg;
    logic [2:0]     status_next;
    logic [2:0]     out_port_reg;
    logic [2:0]     out_port_next;

    // chain moves whenever the output register can take a new result
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // admission: port check, table full check, entry count
    always_comb
    begin
        port_off   = (4'(port_number) >= PORT_LIMIT)
                     || !active_port_mask_reg[port_number];
        table_full = (count_reg >= FULL_COUNT);
        head_tok   = '0;
        head_tok.lookup = (func == lpmt_pkg::FUNC_LOOKUP);
        head_tok.port   = port_number;
        head_tok.len    = (prefix_length > lpmt_pkg::MAX_PREFIX_LEN)
                          ? lpmt_pkg::MAX_PREFIX_LEN : prefix_length;
        head_tok.addr   = head_tok.lookup ? dest_address : prefix_network;
        count_next      = count_reg;
        if (head_tok.lookup)
            head_tok.status = lpmt_pkg::ST_NO_ROUTE;
        else if (port_off)
            head_tok.status = lpmt_pkg::ST_PORT_OFF;
        else if (table_full)
            head_tok.status = lpmt_pkg::ST_FULL;
        else
        begin
            head_tok.status = lpmt_pkg::ST_ADDED;
            head_tok.wr     = 1'b1;
            if (accept)
                count_next = count_reg + 1'b1;
        end
    end

    assign vld[0] = accept;
    assign tok[0] = head_tok;
    assign cnt[0] = count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg            <= '0;
            active_port_mask_reg <= 8'd1;
        end
        else
        begin
            count_reg <= count_next;
            if (active_port_mask_we)
                active_port_mask_reg <= active_port_mask_wdata;
        end
    end

    // chain of entry cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        lpmt_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .vld_in  (vld[i]),
            .tok_in  (tok[i]),
            .cnt_in  (cnt[i]),
            .vld_out (vld[i+1]),
            .tok_out (tok[i+1]),
            .cnt_out (cnt[i+1])
        );
    end

    // final decision from the chain tail
    always_comb
    begin
        status_next   = tok[TABLE_DEPTH].status;
        out_port_next = 3'd0;
        if (tok[TABLE_DEPTH].lookup)
        begin
            if (!tok[TABLE_DEPTH].found)
                status_next = lpmt_pkg::ST_NO_ROUTE;
            else if (tok[TABLE_DEPTH].best_port == tok[TABLE_DEPTH].port)
                status_next = lpmt_pkg::ST_DROP_SAME;
            else
            begin
                status_next   = lpmt_pkg::ST_FORWARD;
                out_port_next = tok[TABLE_DEPTH].best_port;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= vld[TABLE_DEPTH];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg   <= status_next;
            out_port_reg <= out_port_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_port  = out_port_reg;

    // cnt at the tail is only a stage copy; keep it observed
    logic unused_tail;
    assign unused_tail = ^cnt[TABLE_DEPTH];

endmodule

`default_nettype wire

// File: sv/lpmt_checker.sv
// lpmt_checker: port-level assertions for the prefix match table, and the
// bind that attaches them to the top level; depends on lpmt_pkg
`default_nettype none

module lpmt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] status,
    input wire logic [2:0] out_port
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_port))
        else $error("result changed under stall");

    // input is only held off by a waiting, stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // status is a known code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= lpmt_pkg::ST_FULL)
        else $error("status out of range");

    // port is zero unless forwarding
    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != lpmt_pkg::ST_FORWARD |-> out_port == 3'd0)
        else $error("out_port nonzero on non-forward result");

endmodule

bind ipv4_longest_prefix_match_table lpmt_checker u_lpmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_port  (out_port)
);

`default_nettype wire
